// ===== hdl/pal_pkg.sv =====
// Shared types, sizes and helper functions of the positional array list.
package pal_pkg;

  // List capacity and stored entry width.
  localparam int CAPACITY = 128;
  localparam int VALUE_W  = 32;

  // Fixed widths of the command and result fields.
  localparam int POS_W   = 8;
  localparam int FIELD_W = 32;
  localparam int COUNT_W = 8;

  // Derived sizes: entry index, internal count and comparison width.
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Depth of the job queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    CMD_GET    = 2'd0,
    CMD_SET    = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_REMOVE = 2'd3
  } pal_cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } pal_status_e;

  // Memory work that the back end carries out for one command.
  typedef enum logic [2:0] {
    JOB_NONE,
    JOB_GET,
    JOB_SET,
    JOB_INS,
    JOB_REM
  } pal_job_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_SHIFT
  } pal_back_state_e;

  typedef struct packed {
    pal_job_e           kind;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   first;
    logic [IDX_W-1:0]   last;
    logic               shift_en;
    logic [VALUE_W-1:0] value;
    pal_status_e        status;
    logic [CNT_W-1:0]   count;
    logic               neg_one;
  } pal_job_t;

  typedef struct packed {
    pal_status_e        status;
    logic [FIELD_W-1:0] read_value;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    logic               is_full;
  } pal_result_t;

  // Sign-extend the input value and keep it at the stored width.
  function automatic logic [VALUE_W-1:0] widen(input logic signed [FIELD_W-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[VALUE_W-1:0];
  endfunction

  // The low field bits of a stored entry, zero-extended where narrower.
  function automatic logic [FIELD_W-1:0] to_field(input logic [VALUE_W-1:0] e);
    logic [63:0] w;
    w = 64'(e);
    return w[FIELD_W-1:0];
  endfunction

endpackage

// ===== hdl/pal_front.sv =====
// Front end: checks each command against the running count and issues a job.
module pal_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [1:0]                  cmd_i,
  input  logic [pal_pkg::POS_W-1:0]   pos_i,
  input  logic signed [pal_pkg::FIELD_W-1:0] value_i,
  input  logic                        q_full_i,
  output logic                        full_o,
  output logic                        q_push_o,
  output pal_pkg::pal_job_t           job_o
);

  logic [pal_pkg::CNT_W-1:0] count_q, count_d;
  logic [pal_pkg::CMP_W-1:0] pos_w, cnt_w;
  logic                      pos_ok, ins_ok;

  assign full_o   = q_full_i;
  assign q_push_o = push_i && !q_full_i;

  // Classify the command; the count here runs ahead of the back end.
  always_comb begin
    pos_w  = pal_pkg::CMP_W'(pos_i);
    cnt_w  = pal_pkg::CMP_W'(count_q);
    pos_ok = (pos_w != '0) && (pos_w <= cnt_w);
    ins_ok = (pos_w != '0) && (pos_w <= cnt_w + pal_pkg::CMP_W'(1));

    job_o          = '0;
    job_o.kind     = pal_pkg::JOB_NONE;
    job_o.idx      = pal_pkg::IDX_W'(pos_w - pal_pkg::CMP_W'(1));
    job_o.value    = pal_pkg::widen(value_i);
    job_o.status   = pal_pkg::ST_OK;
    job_o.count    = count_q;
    job_o.neg_one  = 1'b0;
    job_o.shift_en = 1'b0;

    unique case (pal_pkg::pal_cmd_e'(cmd_i))
      pal_pkg::CMD_GET: begin
        if (!pos_ok) begin
          job_o.status  = pal_pkg::ST_BAD_POS;
          job_o.neg_one = 1'b1;
        end else begin
          job_o.kind = pal_pkg::JOB_GET;
        end
      end
      pal_pkg::CMD_SET: begin
        if (!pos_ok) begin
          job_o.status = pal_pkg::ST_BAD_POS;
        end else begin
          job_o.kind = pal_pkg::JOB_SET;
        end
      end
      pal_pkg::CMD_INSERT: begin
        if (cnt_w >= pal_pkg::CMP_W'(pal_pkg::CAPACITY)) begin
          job_o.status = pal_pkg::ST_FULL;
        end else if (!ins_ok) begin
          job_o.status = pal_pkg::ST_BAD_POS;
        end else begin
          job_o.kind     = pal_pkg::JOB_INS;
          job_o.first    = pal_pkg::IDX_W'(cnt_w - pal_pkg::CMP_W'(1));
          job_o.last     = pal_pkg::IDX_W'(pos_w - pal_pkg::CMP_W'(1));
          job_o.shift_en = (cnt_w >= pos_w);
          job_o.count    = count_q + pal_pkg::CNT_W'(1);
        end
      end
      pal_pkg::CMD_REMOVE: begin
        if (count_q == '0) begin
          job_o.status = pal_pkg::ST_EMPTY;
        end else if (!pos_ok) begin
          job_o.status = pal_pkg::ST_BAD_POS;
        end else begin
          job_o.kind     = pal_pkg::JOB_REM;
          job_o.first    = pal_pkg::IDX_W'(pos_w);
          job_o.last     = pal_pkg::IDX_W'(cnt_w - pal_pkg::CMP_W'(1));
          job_o.shift_en = (cnt_w > pos_w);
          job_o.count    = count_q - pal_pkg::CNT_W'(1);
        end
      end
      default: begin
        job_o.status = pal_pkg::ST_OK;
      end
    endcase

    count_d = q_push_o ? job_o.count : count_q;
  end

  // Running entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

// ===== hdl/pal_queue.sv =====
// Short job queue that decouples the front end from the back end.
module pal_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pal_pkg::pal_job_t job_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output pal_pkg::pal_job_t job_o
);

  pal_pkg::pal_job_t         slot_q [pal_pkg::QDEPTH];
  logic [pal_pkg::QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [pal_pkg::QPTR_W:0]   fill_q, fill_d;
  logic                       do_push, do_pop;

  assign full_o  = (fill_q == (pal_pkg::QPTR_W+1)'(pal_pkg::QDEPTH));
  assign valid_o = (fill_q != '0);
  assign job_o   = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill updates, wrapping at the queue depth.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (do_push) begin
      wptr_d = (wptr_q == pal_pkg::QPTR_W'(pal_pkg::QDEPTH - 1)) ? '0 :
               wptr_q + pal_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == pal_pkg::QPTR_W'(pal_pkg::QDEPTH - 1)) ? '0 :
               rptr_q + pal_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + (pal_pkg::QPTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - (pal_pkg::QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  // Job storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= job_i;
    end
  end

endmodule

// ===== hdl/pal_back.sv =====
// Back end: entry memory, shift sequencer and result register.
module pal_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_valid_i,
  input  pal_pkg::pal_job_t            job_i,
  output logic                         job_pop_o,
  input  logic                         pop_i,
  output logic                         res_valid_o,
  output pal_pkg::pal_result_t         res_o
);

  logic [pal_pkg::VALUE_W-1:0] mem_q [pal_pkg::CAPACITY];
  logic [pal_pkg::VALUE_W-1:0] rdata_q;

  pal_pkg::pal_back_state_e state_q, state_d;
  pal_pkg::pal_job_t        job_q, job_d;
  logic [pal_pkg::IDX_W-1:0] src_q, src_d, prev_q, prev_d;
  logic                      issue_q, issue_d, pend_q, pend_d;
  logic                      out_valid_q, out_valid_d;
  pal_pkg::pal_result_t      res_q, res_d;
  logic                      res_load;

  logic                        mem_we, mem_re;
  logic [pal_pkg::IDX_W-1:0]   mem_waddr, mem_raddr;
  logic [pal_pkg::VALUE_W-1:0] mem_wdata;
  logic                        slot_free;

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign slot_free   = !out_valid_q || pop_i;

  // Sequencer: one memory read and one write per cycle during a shift.
  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    src_d     = src_q;
    prev_d    = prev_q;
    issue_d   = issue_q;
    pend_d    = 1'b0;
    job_pop_o = 1'b0;
    res_load  = 1'b0;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = job_q.idx;
    mem_raddr = src_q;
    mem_wdata = job_q.value;

    unique case (state_q)
      pal_pkg::B_IDLE: begin
        if (job_valid_i && slot_free) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          res_d.status     = job_i.status;
          res_d.read_value = job_i.neg_one ? '1 : '0;
          res_d.count      = pal_pkg::COUNT_W'(job_i.count);
          res_d.is_empty   = (job_i.count == '0);
          res_d.is_full    = (job_i.count == pal_pkg::CNT_W'(pal_pkg::CAPACITY));
          priority if (job_i.kind == pal_pkg::JOB_GET) begin
            mem_re    = 1'b1;
            mem_raddr = job_i.idx;
            state_d   = pal_pkg::B_READ;
          end else if ((job_i.kind == pal_pkg::JOB_INS ||
                        job_i.kind == pal_pkg::JOB_REM) && job_i.shift_en) begin
            src_d   = job_i.first;
            issue_d = 1'b1;
            state_d = pal_pkg::B_SHIFT;
          end else begin
            // Set, insert at the end, removal of the last entry, or refusal.
            res_load  = 1'b1;
            mem_we    = (job_i.kind == pal_pkg::JOB_SET) ||
                        (job_i.kind == pal_pkg::JOB_INS);
            mem_waddr = job_i.idx;
            mem_wdata = job_i.value;
          end
        end
      end
      pal_pkg::B_READ: begin
        res_d.read_value = pal_pkg::to_field(rdata_q);
        res_load         = 1'b1;
        state_d          = pal_pkg::B_IDLE;
      end
      pal_pkg::B_SHIFT: begin
        // Issue the next source read.
        if (issue_q) begin
          mem_re    = 1'b1;
          mem_raddr = src_q;
          pend_d    = 1'b1;
          prev_d    = src_q;
          if (src_q == job_q.last) begin
            issue_d = 1'b0;
          end else if (job_q.kind == pal_pkg::JOB_INS) begin
            src_d = src_q - pal_pkg::IDX_W'(1);
          end else begin
            src_d = src_q + pal_pkg::IDX_W'(1);
          end
        end
        // Write back the entry read in the previous cycle one place over.
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_wdata = rdata_q;
          mem_waddr = (job_q.kind == pal_pkg::JOB_INS) ? prev_q + pal_pkg::IDX_W'(1) :
                                                         prev_q - pal_pkg::IDX_W'(1);
        end
        // Shift drained: an insert fills the gap, then the result is posted.
        if (!issue_q && !pend_q) begin
          mem_we    = (job_q.kind == pal_pkg::JOB_INS);
          mem_waddr = job_q.idx;
          mem_wdata = job_q.value;
          res_load  = 1'b1;
          state_d   = pal_pkg::B_IDLE;
        end
      end
      default: begin
        state_d = pal_pkg::B_IDLE;
      end
    endcase

    if (res_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && !pop_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pal_pkg::B_IDLE;
      issue_q     <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers of the sequencer and the result.
  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    src_q  <= src_d;
    prev_q <= prev_d;
    res_q  <= res_d;
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

endmodule

// ===== hdl/positional_array_list.sv =====
// Top level of the positional array list: front end, job queue and back end.
//
// A fixed-capacity ordered list of signed values addressed by 1-based
// position, driven through queue-style ports: a command is taken while full
// is low, and each command gives exactly one result, oldest first, while
// empty is low. The front end checks every command against its own running
// count, so refused commands and status are settled at once; the back end
// does the memory work. Get reads the entry memory in a read state before
// its result is posted; set and refused commands finish in the idle state.
// Insert and remove move every entry behind the position through the single
// entry memory, one read and one write a cycle, in the shift state. The
// entry memory needs no clearing after reset: only positions that were
// written are ever read.
module positional_array_list (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic [1:0]                         cmd_i,
  input  logic [pal_pkg::POS_W-1:0]          pos_i,
  input  logic signed [pal_pkg::FIELD_W-1:0] value_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [1:0]                         status_o,
  output logic signed [pal_pkg::FIELD_W-1:0] read_value_o,
  output logic [pal_pkg::COUNT_W-1:0]        count_o,
  output logic                               is_empty_o,
  output logic                               is_full_o
);

  pal_pkg::pal_job_t    front_job, back_job;
  pal_pkg::pal_result_t res;
  logic                 q_push, q_full, q_valid, q_pop, res_valid;

  pal_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (cmd_i),
    .pos_i    (pos_i),
    .value_i  (value_i),
    .q_full_i (q_full),
    .full_o   (full),
    .q_push_o (q_push),
    .job_o    (front_job)
  );

  pal_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (front_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (back_job)
  );

  pal_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (back_job),
    .job_pop_o   (q_pop),
    .pop_i       (pop),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result ports.
  assign empty        = !res_valid;
  assign status_o     = res.status;
  assign read_value_o = res.read_value;
  assign count_o      = res.count;
  assign is_empty_o   = res.is_empty;
  assign is_full_o    = res.is_full;

endmodule

// ===== hdl/pal_checker.sv =====
// Port-level checks of the positional array list and their binding.
module pal_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               empty,
  input logic                               pop,
  input logic [1:0]                         status_o,
  input logic [pal_pkg::COUNT_W-1:0]        count_o,
  input logic                               is_empty_o,
  input logic                               is_full_o
);

  // A waiting result is not withdrawn before its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result withdrawn before transfer");

  // An empty list reports a count of zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && is_empty_o) |-> (count_o == '0))
    else $error("empty flag with non-zero count");

  // A refused insert leaves the list full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == pal_pkg::ST_FULL) |-> (is_full_o && !is_empty_o))
    else $error("list-full status without full flag");

  // A refused remove leaves the list empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == pal_pkg::ST_EMPTY) |-> (is_empty_o && !is_full_o))
    else $error("list-empty status without empty flag");

endmodule

bind positional_array_list pal_checker u_pal_checker (.*);
